// ===== sv/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance-vector route table package
// Shared transaction types, status codes and the token that walks the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

	// Token index and count fields are sized for the largest supported table.
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	localparam logic [15:0] DIST_MAX = 16'hFFFF;
	localparam logic [7:0]  EXPIRY_RST = 8'd16;

	localparam logic [1:0] OP_ADV    = 2'd0;
	localparam logic [1:0] OP_AGE    = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_RSVD   = 2'd3;

	typedef enum logic [2:0] {
		ST_INSTALLED = 3'd0,
		ST_KEPT      = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_AGED      = 3'd3,
		ST_HIT       = 3'd4,
		ST_MISS      = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] dest_addr;
		logic [31:0] hop_addr;
		logic [31:0] hop_mac;
		logic [15:0] adv_distance;
		logic [15:0] link_distance;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [31:0] route_hop_addr;
		logic [31:0] route_hop_mac;
		logic [15:0] route_distance;
		logic [5:0]  entries_used;
	} rsp_t;

	// Token handed from cell to cell, one cell per cycle.
	typedef struct packed {
		logic             valid;
		logic [1:0]       op;
		logic [31:0]      dest;
		logic [31:0]      hop_addr;
		logic [31:0]      hop_mac;
		logic [15:0]      new_dist;
		logic             match;
		logic             inst;
		logic [15:0]      rdist;
		logic [31:0]      r_hop_addr;
		logic [31:0]      r_hop_mac;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
		logic [CNT_W-1:0] count;
	} token_t;

	// Install of a new destination into the chosen free cell.
	typedef struct packed {
		logic             wr;
		logic [IDX_W-1:0] idx;
		logic [31:0]      dest;
		logic [31:0]      hop_addr;
		logic [31:0]      hop_mac;
		logic [15:0]      distance;
	} install_t;

endpackage

`default_nettype wire

// ===== sv/dvrt_cell.sv =====
// ----------------------------------------------------------------------------
// Route table cell
// Holds one route entry, updates it as the token passes and registers the token.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_cell #(
	parameter int IDX = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       expiry_init,
	input  wire dvrt_pkg::token_t tok_i,
	input  wire dvrt_pkg::install_t ins,
	output dvrt_pkg::token_t      tok_o
);
	import dvrt_pkg::*;

	logic        valid_q;
	logic [31:0] dest_q;
	logic [31:0] hop_addr_q;
	logic [31:0] hop_mac_q;
	logic [15:0] dist_q;
	logic [7:0]  ttl_q;

	logic        valid_d;
	logic        upd;
	logic        hit;
	logic        ins_me;
	logic [7:0]  ttl_d;
	token_t      tok_d;

	assign hit    = valid_q && (dest_q == tok_i.dest);
	assign ins_me = ins.wr && (ins.idx == IDX_W'(IDX));

	always_comb begin
		tok_d   = tok_i;
		valid_d = valid_q;
		ttl_d   = ttl_q;
		upd     = 1'b0;
		if (tok_i.valid) begin
			case (tok_i.op)
				OP_ADV: begin
					if (hit) begin
						tok_d.match = 1'b1;
						if (tok_i.new_dist < dist_q) begin
							upd        = 1'b1;
							tok_d.inst = 1'b1;
							tok_d.rdist = tok_i.new_dist;
						end else begin
							tok_d.rdist = dist_q;
						end
					end else if (!valid_q && !tok_i.free_found) begin
						tok_d.free_found = 1'b1;
						tok_d.free_idx   = IDX_W'(IDX);
					end
				end
				OP_AGE: begin
					if (valid_q) begin
						if (ttl_q <= 8'd1) valid_d = 1'b0;
						else ttl_d = ttl_q - 8'd1;
					end
				end
				OP_LOOKUP: begin
					if (hit) begin
						tok_d.match      = 1'b1;
						tok_d.rdist      = dist_q;
						tok_d.r_hop_addr = hop_addr_q;
						tok_d.r_hop_mac  = hop_mac_q;
					end
				end
				default: begin
				end
			endcase
			tok_d.count = tok_i.count + CNT_W'(valid_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_o   <= '0;
		end else begin
			tok_o <= tok_d;
			if (ins_me) valid_q <= 1'b1;
			else valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_me) begin
			dest_q     <= ins.dest;
			hop_addr_q <= ins.hop_addr;
			hop_mac_q  <= ins.hop_mac;
			dist_q     <= ins.distance;
			ttl_q      <= expiry_init;
		end else if (upd) begin
			hop_addr_q <= tok_i.hop_addr;
			hop_mac_q  <= tok_i.hop_mac;
			dist_q     <= tok_i.new_dist;
			ttl_q      <= expiry_init;
		end else begin
			ttl_q <= ttl_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/distance_vector_route_table.sv =====
// ----------------------------------------------------------------------------
// Distance-vector route table
// Bounded route table built as a chain of entry cells walked by a token.
// ----------------------------------------------------------------------------
// Usage: a command transaction is accepted at a rising edge where start is
// high and busy is low. The command carries an op: an advertised route, an
// end-of-batch aging pass, or a lookup. The command becomes a token that
// moves through the chain of TABLE_ENTRIES cells, one cell per cycle; each
// cell compares, ages or refreshes its own entry as the token passes.
// When the token leaves the last cell, a new destination is written into the
// lowest free cell found on the way (a broadcast write), and the response
// transaction is registered. done is high for exactly one cycle with the
// response on rsp; the receiver cannot stall, so it must take it then.
// The token passes the head register and every cell register in turn, and
// done is registered from the last cell; busy stays high until the token
// leaves the last cell, so a new command waits until the chain is empty.
// cfg_we writes the expiry count from cfg_wdata; write it only while idle.
// Reset clears all valid marks, the token chain and sets the expiry to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_table #(
	parameter int TABLE_ENTRIES = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire dvrt_pkg::cmd_t cmd,
	output logic                done,
	output dvrt_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic [7:0]     cfg_wdata
);
	import dvrt_pkg::*;

	logic       busy_q;
	logic       done_q;
	rsp_t       rsp_q;
	logic [7:0] expiry_cfg_q;
	token_t     tok_q;
	token_t     tok_s [TABLE_ENTRIES];
	token_t     last;
	install_t   ins;
	logic       accept;
	logic [16:0] sum;
	logic [CNT_W-1:0] cnt_final;
	rsp_t       rsp_d;
	logic [TABLE_ENTRIES:0] tok_valids;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign sum    = {1'b0, cmd.adv_distance} + {1'b0, cmd.link_distance};

	// Head of the chain: the accepted command turned into a fresh token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q        <= '0;
			expiry_cfg_q <= EXPIRY_RST;
		end else begin
			tok_q.valid <= accept;
			if (cfg_we) expiry_cfg_q <= cfg_wdata;
			if (accept) begin
				tok_q.op         <= cmd.op;
				tok_q.dest       <= cmd.dest_addr;
				tok_q.hop_addr   <= cmd.hop_addr;
				tok_q.hop_mac    <= cmd.hop_mac;
				tok_q.new_dist   <= sum[16] ? DIST_MAX : sum[15:0];
				tok_q.match      <= 1'b0;
				tok_q.inst       <= 1'b0;
				tok_q.rdist      <= '0;
				tok_q.r_hop_addr <= '0;
				tok_q.r_hop_mac  <= '0;
				tok_q.free_found <= 1'b0;
				tok_q.free_idx   <= '0;
				tok_q.count      <= '0;
			end
		end
	end

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		dvrt_cell #(.IDX(g)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.expiry_init (expiry_cfg_q),
			.tok_i       ((g == 0) ? tok_q : tok_s[(g == 0) ? 0 : g - 1]),
			.ins         (ins),
			.tok_o       (tok_s[g])
		);
		assign tok_valids[g + 1] = tok_s[g].valid;
	end
	assign tok_valids[0] = tok_q.valid;

	assign last = tok_s[TABLE_ENTRIES-1];

	// A new destination goes into the lowest free cell seen by the token.
	always_comb begin
		ins.wr       = last.valid && (last.op == OP_ADV) && !last.match && last.free_found;
		ins.idx      = last.free_idx;
		ins.dest     = last.dest;
		ins.hop_addr = last.hop_addr;
		ins.hop_mac  = last.hop_mac;
		ins.distance = last.new_dist;
	end

	assign cnt_final = last.count + CNT_W'(ins.wr);

	always_comb begin
		rsp_d = '0;
		rsp_d.entries_used = (cnt_final > CNT_W'(63)) ? 6'd63 : cnt_final[5:0];
		case (last.op)
			OP_ADV: begin
				if (last.match) begin
					rsp_d.status = last.inst ? ST_INSTALLED : ST_KEPT;
					rsp_d.route_distance = last.rdist;
				end else begin
					rsp_d.status = last.free_found ? ST_INSTALLED : ST_DROPPED;
					rsp_d.route_distance = last.new_dist;
				end
			end
			OP_AGE: begin
				rsp_d.status = ST_AGED;
			end
			OP_LOOKUP: begin
				if (last.match) begin
					rsp_d.status         = ST_HIT;
					rsp_d.found          = 1'b1;
					rsp_d.route_hop_addr = last.r_hop_addr;
					rsp_d.route_hop_mac  = last.r_hop_mac;
					rsp_d.route_distance = last.rdist;
				end else begin
					rsp_d.status = ST_MISS;
				end
			end
			default: begin
				rsp_d.status = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
			if (accept) busy_q <= 1'b1;
			else if (last.valid) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last.valid) rsp_q <= rsp_d;
	end

	// Only one token is ever in flight.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valids))
		else $error("more than one token in the cell chain");

	// A token in the chain implies the block reports busy.
	a_busy_token: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valids != '0) |-> busy_q)
		else $error("token in flight while not busy");

	// A response is issued in the cycle after the token leaves the last cell.
	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		last.valid |=> (done_q && !busy_q))
		else $error("response not issued after the chain");

	// The valid count can never exceed the table size.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		last.valid |-> (cnt_final <= CNT_W'(TABLE_ENTRIES)))
		else $error("entry count exceeds table size");

endmodule

`default_nettype wire

// ===== tb/distance_vector_route_table_tb.sv =====
// ----------------------------------------------------------------------------
// Distance-vector route table testbench
// Drives advertisements, aging passes, lookups and reserved ops into the table while the
// expiry register is changed between phases. A scoreboard keeps its own
// copy of the table and checks every response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class route_scoreboard;
	bit        ent_valid [32];
	bit [31:0] ent_dest [32];
	bit [31:0] ent_hop_addr [32];
	bit [31:0] ent_hop_mac [32];
	bit [15:0] ent_dist [32];
	bit [7:0]  ent_ttl [32];
	bit [7:0]  expiry;
	dvrt_pkg::rsp_t pending_rsp [$];
	int        errors;

	function void clear_table();
		foreach (ent_valid[i]) ent_valid[i] = 0;
		expiry = dvrt_pkg::EXPIRY_RST;
		errors = 0;
	endfunction

	function int find_dest(bit [31:0] d);
		foreach (ent_valid[i])
			if (ent_valid[i] && ent_dest[i] == d) return i;
		return -1;
	endfunction

	function int valid_count();
		int n;
		n = 0;
		foreach (ent_valid[i]) n += ent_valid[i];
		return n;
	endfunction

	// Applies one accepted command to the table copy and queues its response.
	function void note_command(dvrt_pkg::cmd_t c);
		dvrt_pkg::rsp_t r;
		bit [16:0] sum;
		bit [15:0] nd;
		int i;
		r = '0;
		r.status = dvrt_pkg::ST_MISS;
		if (c.op == dvrt_pkg::OP_ADV) begin
			sum = c.adv_distance + c.link_distance;
			nd = sum[16] ? dvrt_pkg::DIST_MAX : sum[15:0];
			i = find_dest(c.dest_addr);
			if (i < 0) begin
				foreach (ent_valid[k])
					if (!ent_valid[k] && i < 0) i = k;
				r.status = (i < 0) ? dvrt_pkg::ST_DROPPED : dvrt_pkg::ST_INSTALLED;
			end else
				r.status = (nd < ent_dist[i]) ? dvrt_pkg::ST_INSTALLED : dvrt_pkg::ST_KEPT;
			if (r.status == dvrt_pkg::ST_INSTALLED) begin
				ent_valid[i] = 1;
				ent_dest[i] = c.dest_addr;
				ent_hop_addr[i] = c.hop_addr;
				ent_hop_mac[i] = c.hop_mac;
				ent_dist[i] = nd;
				ent_ttl[i] = expiry;
			end
			r.route_distance = (r.status == dvrt_pkg::ST_KEPT) ? ent_dist[i] : nd;
		end else if (c.op == dvrt_pkg::OP_AGE) begin
			foreach (ent_valid[k])
				if (ent_valid[k]) begin
					if (ent_ttl[k] <= 1) ent_valid[k] = 0;
					else ent_ttl[k]--;
				end
			r.status = dvrt_pkg::ST_AGED;
		end else if (c.op == dvrt_pkg::OP_LOOKUP) begin
			i = find_dest(c.dest_addr);
			if (i >= 0) begin
				r.status = dvrt_pkg::ST_HIT;
				r.found = 1;
				r.route_hop_addr = ent_hop_addr[i];
				r.route_hop_mac = ent_hop_mac[i];
				r.route_distance = ent_dist[i];
			end
		end
		r.entries_used = 6'(valid_count());
		pending_rsp.push_back(r);
	endfunction

	function void check_response(dvrt_pkg::rsp_t got);
		dvrt_pkg::rsp_t exp;
		if (pending_rsp.size() == 0) begin
			$display("%0t: unexpected response %h", $time, got);
			errors++;
			return;
		end
		exp = pending_rsp.pop_front();
		if (got.status !== exp.status)
			$display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
		if (got.found !== exp.found)
			$display("%0t: found exp %0d got %0d", $time, exp.found, got.found);
		if (got.route_hop_addr !== exp.route_hop_addr)
			$display("%0t: hop_addr exp %h got %h", $time, exp.route_hop_addr,
				got.route_hop_addr);
		if (got.route_hop_mac !== exp.route_hop_mac)
			$display("%0t: hop_mac exp %h got %h", $time, exp.route_hop_mac,
				got.route_hop_mac);
		if (got.route_distance !== exp.route_distance)
			$display("%0t: distance exp %0d got %0d", $time, exp.route_distance,
				got.route_distance);
		if (got.entries_used !== exp.entries_used)
			$display("%0t: entries_used exp %0d got %0d", $time, exp.entries_used,
				got.entries_used);
		if (got !== exp) errors++;
	endfunction
endclass

module distance_vector_route_table_tb;
	import dvrt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       start = 0;
	logic       busy;
	cmd_t       cmd = '0;
	logic       done;
	rsp_t       rsp;
	logic       cfg_we = 0;
	logic [7:0] cfg_wdata = '0;

	route_scoreboard sb;
	int         idle_pct;
	int         stall_count;
	// A small pool of destinations keeps advertisements hitting existing
	// routes and lookups finding them; the wide pool fills the table.
	bit [31:0]  dest_pool [48];

	distance_vector_route_table #(.TABLE_ENTRIES(32)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Responses are sampled at the rising edge; the block cannot be stalled.
	always @(posedge clk) begin
		if (arst_n && done) sb.check_response(rsp);
	end

	// The watchdog counts cycles in which no transaction of either kind occurs.
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) stall_count <= 0;
		else stall_count <= stall_count + 1;
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Sends one command. The task is entered at a falling edge with start low
	// and raises start only at a falling edge where busy is already low, so
	// the following rising edge accepts the transaction. start is dropped at
	// the falling edge after the accept, once per edge.
	task automatic send_command(cmd_t c);
		while (busy || ($urandom_range(99) < idle_pct)) @(negedge clk);
		cmd <= c;
		start <= 1;
		@(posedge clk);
		sb.note_command(c);
		@(negedge clk);
		start <= 0;
	endtask

	// Waits for the block to drain before a register write.
	task automatic wait_drained();
		while (sb.pending_rsp.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_expiry(bit [7:0] v);
		wait_drained();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.expiry = v;
	endtask

	function automatic cmd_t make_cmd(bit [1:0] op, bit [31:0] d, bit [15:0] adv,
		bit [15:0] link);
		cmd_t c;
		c.op = op;
		c.dest_addr = d;
		c.hop_addr = $urandom;
		c.hop_mac = $urandom;
		c.adv_distance = adv;
		c.link_distance = link;
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		int r;
		bit [31:0] d;
		bit [15:0] adv, link;
		r = $urandom_range(99);
		d = ($urandom_range(3) == 0) ? $urandom : dest_pool[$urandom_range(47)];
		adv = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(300));
		link = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(300));
		if (r < 55) return make_cmd(OP_ADV, d, adv, link);
		if (r < 65) return make_cmd(OP_AGE, $urandom, 16'($urandom), 16'($urandom));
		if (r < 97) return make_cmd(OP_LOOKUP, d, 16'($urandom), 16'($urandom));
		return make_cmd(OP_RSVD, d, 16'($urandom), 16'($urandom));
	endfunction

	task automatic random_phase(int n, int pct);
		idle_pct = pct;
		repeat (n) send_command(random_cmd());
	endtask

	initial begin
		sb = new();
		sb.clear_table();
		stall_count = 0;
		foreach (dest_pool[i]) dest_pool[i] = $urandom;
		dest_pool[0] = '0;
		dest_pool[1] = '1;
		idle_pct = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;

		// Directed part: field extremes, saturation, equal and shorter
		// distances, every op, lowest free slot after aging frees entries.
		send_command(make_cmd(OP_LOOKUP, 32'h0, 16'h0, 16'h0));
		send_command(make_cmd(OP_ADV, 32'h0, 16'h0, 16'h0));
		send_command(make_cmd(OP_ADV, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
		send_command(make_cmd(OP_ADV, 32'hFFFF_FFFF, 16'hFFFF, 16'h0));
		send_command(make_cmd(OP_ADV, 32'hFFFF_FFFF, 16'h8000, 16'h7FFE));
		send_command(make_cmd(OP_ADV, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF));
		send_command(make_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 16'h0));
		send_command(make_cmd(OP_RSVD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
		send_command(make_cmd(OP_AGE, 32'h0, 16'h0, 16'h0));
		write_expiry(8'd1);
		send_command(make_cmd(OP_ADV, 32'h1234_5678, 16'd5, 16'd5));
		send_command(make_cmd(OP_AGE, 32'h0, 16'h0, 16'h0));
		send_command(make_cmd(OP_LOOKUP, 32'h1234_5678, 16'h0, 16'h0));

		// Fill the table past its size so that new destinations are dropped.
		write_expiry(8'd255);
		for (int i = 0; i < 34; i++)
			send_command(make_cmd(OP_ADV, $urandom, 16'($urandom_range(100)), 16'd1));

		// Random phases: the sender idles rarely first, then often, then never.
		random_phase(150, 12);
		write_expiry(8'd2);
		random_phase(200, 12);
		write_expiry(8'd1);
		random_phase(150, 72);
		write_expiry(8'd16);
		random_phase(200, 72);
		write_expiry(8'd4);
		random_phase(200, 0);
		write_expiry(8'd0);
		random_phase(50, 0);

		wait_drained();
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

`default_nettype wire
